// ===== src/tdpc_pkg.sv =====
// Package for the trial division prime counter: transaction payload types,
// fixed field widths, microcode step types and the microcode program table.
// Has no dependencies; the top level imports it.
package tdpc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 16;
  localparam int DIV_BITS    = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS     = VALUE_BITS + 1;
  localparam int BITCNT_BITS = $clog2(VALUE_BITS);
  localparam int UPC_BITS    = 3;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_item;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value_out;
    logic                         prime_flag;
    logic [COUNT_BITS-1:0]        prime_count;
    logic                         last_out;
  } out_t;

  typedef logic [UPC_BITS-1:0] upc_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_INPUT,
    C_BELOW_TWO,
    C_SQ_ABOVE,
    C_BITS_LEFT,
    C_DIVIDES,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_INIT,
    A_START_DIV,
    A_DIV_STEP,
    A_NEXT_DIV,
    A_SET_PRIME,
    A_EMIT
  } act_e;

  typedef struct packed {
    cond_e cond;
    act_e  act;
    upc_t  target;
  } ctrl_t;

  localparam upc_t U_WAIT  = 3'd0;
  localparam upc_t U_CHECK = 3'd1;
  localparam upc_t U_LOOP  = 3'd2;
  localparam upc_t U_DIV   = 3'd3;
  localparam upc_t U_TEST  = 3'd4;
  localparam upc_t U_BACK  = 3'd5;
  localparam upc_t U_PRIME = 3'd6;
  localparam upc_t U_DONE  = 3'd7;

  // A taken condition jumps to the target; otherwise the step counter advances,
  // and the step after the final one is the wait step again.
  function automatic ctrl_t ucode_rom(input upc_t upc);
    ctrl_t w;
    case (upc)
      U_WAIT:  w = '{cond: C_NO_INPUT,  act: A_LOAD,      target: U_WAIT};
      U_CHECK: w = '{cond: C_BELOW_TWO, act: A_INIT,      target: U_DONE};
      U_LOOP:  w = '{cond: C_SQ_ABOVE,  act: A_START_DIV, target: U_PRIME};
      U_DIV:   w = '{cond: C_BITS_LEFT, act: A_DIV_STEP,  target: U_DIV};
      U_TEST:  w = '{cond: C_DIVIDES,   act: A_NEXT_DIV,  target: U_DONE};
      U_BACK:  w = '{cond: C_ALWAYS,    act: A_NONE,      target: U_LOOP};
      U_PRIME: w = '{cond: C_NEVER,     act: A_SET_PRIME, target: U_WAIT};
      U_DONE:  w = '{cond: C_OUT_BUSY,  act: A_EMIT,      target: U_DONE};
      default: w = '{cond: C_ALWAYS,    act: A_NONE,      target: U_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/trial_division_prime_counter.sv =====
// Trial division prime counter driven by a microcode table from tdpc_pkg.
// Values below two are reported as not prime without any division. Otherwise each
// trial divisor from two upward runs a bit-serial remainder plus three sequencing
// steps, until one divides (composite) or its square exceeds the value (prime).
// One transaction is processed at a time; a finished result waits in the output
// register while the next input is taken.
// Reset clears control and the count.
module trial_division_prime_counter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tdpc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tdpc_pkg::out_t  out_data_o
);
  import tdpc_pkg::*;

  upc_t                   upc_q, upc_d;
  ctrl_t                  ctrl;
  logic                   take;
  logic                   out_valid_q;
  logic                   out_busy;
  logic                   emit;
  out_t                   out_data_q;
  logic [COUNT_BITS-1:0]  count_q, count_next;
  logic [VALUE_BITS-1:0]  v_q, sh_q;
  logic                   last_q;
  logic                   prime_q;
  logic [DIV_BITS-1:0]    d_q, rem_q, rem_next;
  logic [SQ_BITS-1:0]     sq_q;
  logic [BITCNT_BITS-1:0] bitcnt_q;
  logic [DIV_BITS:0]      rem_shift;
  logic                   rem_ge;

  assign out_busy   = out_valid_q && out_stall_i;
  assign emit       = (ctrl.act == A_EMIT) && !out_busy;
  assign count_next = (prime_q && (count_q != '1)) ? count_q + 1'b1 : count_q;
  assign rem_shift  = {rem_q, sh_q[VALUE_BITS-1]};
  assign rem_ge     = rem_shift >= {1'b0, d_q};
  assign rem_next   = rem_ge ? DIV_BITS'(rem_shift - {1'b0, d_q})
                             : rem_shift[DIV_BITS-1:0];

  always_comb begin
    ctrl = ucode_rom(upc_q);
    case (ctrl.cond)
      C_ALWAYS:    take = 1'b1;
      C_NEVER:     take = 1'b0;
      C_NO_INPUT:  take = !in_valid_i;
      C_BELOW_TWO: take = v_q[VALUE_BITS-1] || (v_q < VALUE_BITS'(2));
      C_SQ_ABOVE:  take = sq_q > {1'b0, v_q};
      C_BITS_LEFT: take = bitcnt_q != '0;
      C_DIVIDES:   take = rem_q == '0;
      C_OUT_BUSY:  take = out_busy;
      default:     take = 1'b0;
    endcase
    upc_d      = take ? ctrl.target : upc_q + 1'b1;
    in_stall_o = upc_q != U_WAIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_WAIT;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      upc_q <= upc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        count_q     <= last_q ? '0 : count_next;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.act)
      A_LOAD: begin
        if (in_valid_i) begin
          v_q    <= in_data_i.value;
          last_q <= in_data_i.last_item;
        end
      end
      A_INIT: begin
        d_q     <= DIV_BITS'(2);
        sq_q    <= SQ_BITS'(4);
        prime_q <= 1'b0;
      end
      A_START_DIV: begin
        rem_q    <= '0;
        sh_q     <= v_q;
        bitcnt_q <= BITCNT_BITS'(VALUE_BITS - 1);
      end
      A_DIV_STEP: begin
        rem_q    <= rem_next;
        sh_q     <= sh_q << 1;
        bitcnt_q <= bitcnt_q - 1'b1;
      end
      A_NEXT_DIV: begin
        d_q  <= d_q + 1'b1;
        sq_q <= sq_q + SQ_BITS'({d_q, 1'b1});
      end
      A_SET_PRIME: begin
        prime_q <= 1'b1;
      end
      A_EMIT: begin
        if (!out_busy) begin
          out_data_q.value_out   <= v_q;
          out_data_q.prime_flag  <= prime_q;
          out_data_q.prime_count <= count_next;
          out_data_q.last_out    <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A prime result is always a positive value of at least two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prime_flag |->
      !out_data_o.value_out[VALUE_BITS-1] && (out_data_o.value_out > 1))
    else $error("prime flag on a value below two");

  // A prime result always carries a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prime_flag |-> out_data_o.prime_count != '0)
    else $error("prime reported with zero count");

  // The partial remainder stays below the divisor, which is at least two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == U_DIV) || (upc_q == U_TEST) |-> (rem_q < d_q) && (d_q >= DIV_BITS'(2)))
    else $error("remainder out of range");

  // A new result is loaded only when the previous one has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("pending result overwritten");

endmodule

// ===== tb/tb_trial_division_prime_counter.sv =====
// Self-checking testbench for trial_division_prime_counter: a directed table
// and random arrays, each result checked in order.
// Depends on tdpc_pkg for the transaction payload types.
`timescale 1ns / 100ps

module tb_trial_division_prime_counter;
  import tdpc_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  typed;
    logic                  prime;
    logic [COUNT_BITS-1:0] count;
  } dir_row_t;

  localparam int DIR_ROWS_N = 20;
  localparam int RANDOM_ITEMS = 100;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{32'd0,          1'b0, 1'b1, 1'b0, 16'd0},
    '{32'd1,          1'b0, 1'b1, 1'b0, 16'd0},
    '{32'hFFFF_FFFF,  1'b0, 1'b1, 1'b0, 16'd0},
    '{32'h8000_0000,  1'b0, 1'b1, 1'b0, 16'd0},
    '{32'd2,          1'b0, 1'b1, 1'b1, 16'd1},
    '{32'd3,          1'b0, 1'b1, 1'b1, 16'd2},
    '{32'd4,          1'b0, 1'b1, 1'b0, 16'd2},
    '{32'h7FFF_FFFE,  1'b0, 1'b1, 1'b0, 16'd2},
    '{32'd9,          1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd25,         1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd65521,      1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd65535,      1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd97,         1'b1, 1'b0, 1'b0, 16'd0},
    '{32'd2,          1'b1, 1'b1, 1'b1, 16'd1},
    '{32'd0,          1'b1, 1'b1, 1'b0, 16'd0},
    '{32'd7,          1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd49,         1'b0, 1'b0, 1'b0, 16'd0},
    '{32'h7FFF_FFFD,  1'b0, 1'b0, 1'b0, 16'd0},
    '{32'h4000_0000,  1'b0, 1'b0, 1'b0, 16'd0},
    '{32'd11,         1'b1, 1'b0, 1'b0, 16'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  out_t                  expected_results [$];
  logic [COUNT_BITS-1:0] prime_tally = '0;
  int                    mismatch_count = 0;
  bit                    idle_on = 1'b1;

  trial_division_prime_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit is_prime_value(logic [VALUE_BITS-1:0] v);
    longint unsigned n;
    longint unsigned d;
    n = v;
    if (v[VALUE_BITS-1] || n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_t predict_prime_result(in_t item);
    out_t r;
    bit   p;
    p = is_prime_value(item.value);
    if (p && prime_tally != COUNT_FULL) prime_tally = prime_tally + 1'b1;
    r.value_out   = item.value;
    r.prime_flag  = p;
    r.prime_count = prime_tally;
    r.last_out    = item.last_item;
    if (item.last_item) prime_tally = '0;
    return r;
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 4095);
      4, 5:       v = {1'b1, 31'($urandom)};
      6, 7:       v = {1'b0, 30'($urandom), 1'b0};
      8:          v = $urandom_range(0, 3);
      default:    v = $urandom_range(0, 65535);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string field, input longint e, input longint a);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
  endtask

  task automatic send_item(input in_t item, input out_t exp, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(exp);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int   n;
    out_t exp;
    @(posedge rst_ni);
    forever begin
      n = idle_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        exp = expected_results.pop_front();
        if (out_data_o.value_out !== exp.value_out)
          report_mismatch("value_out", exp.value_out, out_data_o.value_out);
        if (out_data_o.prime_flag !== exp.prime_flag)
          report_mismatch("prime_flag", exp.prime_flag, out_data_o.prime_flag);
        if (out_data_o.prime_count !== exp.prime_count)
          report_mismatch("prime_count", exp.prime_count, out_data_o.prime_count);
        if (out_data_o.last_out !== exp.last_out)
          report_mismatch("last_out", exp.last_out, out_data_o.last_out);
      end
    end
  end

  initial begin
    in_t  item;
    out_t exp;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_ROWS[i]) begin
      item.value     = DIR_ROWS[i].value;
      item.last_item = DIR_ROWS[i].last;
      exp = predict_prime_result(item);
      if (DIR_ROWS[i].typed)
        exp = '{value_out: DIR_ROWS[i].value, prime_flag: DIR_ROWS[i].prime,
                prime_count: DIR_ROWS[i].count, last_out: DIR_ROWS[i].last};
      send_item(item, exp, $urandom_range(0, 11));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on        = (i % 40) < 30;
      item.value     = random_value();
      item.last_item = ($urandom_range(0, 5) == 0);
      exp = predict_prime_result(item);
      send_item(item, exp, idle_on ? $urandom_range(0, 11) : 0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
